// ===== design/zrfd_pkg.sv =====
// Shared types and constants for the raw/RLE frame decoder.
// Holds the word structs of both channels, result codes and queue sizing.
// No dependencies.
package zrfd_pkg;

    localparam logic [31:0] FRAME_MAGIC   = 32'hFD2FB528;
    localparam logic [31:0] CAPACITY_RST  = 32'd1048576;

    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_RUN    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_MAGIC   = 4'd1;
    localparam logic [3:0] ST_HDR_TRUNC   = 4'd2;
    localparam logic [3:0] ST_SIZE_TRUNC  = 4'd3;
    localparam logic [3:0] ST_BHDR_TRUNC  = 4'd4;
    localparam logic [3:0] ST_RAW_ERR     = 4'd5;
    localparam logic [3:0] ST_RLE_ERR     = 4'd6;
    localparam logic [3:0] ST_BAD_TYPE    = 4'd7;
    localparam logic [3:0] ST_SIZE_MISM   = 4'd8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_value;
        logic [20:0] run_length;
        logic [3:0]  status;
        logic [31:0] out_total;
        logic        out_last;
    } t_out_word;

    typedef struct packed {
        logic      data_v;
        logic      stat_v;
        t_out_word data_w;
        t_out_word stat_w;
    } t_push;

endpackage

// ===== design/zrfd_apb.sv =====
// Configuration register block with an APB-style slave port.
// Holds the output capacity limit; depends on zrfd_pkg.
module zrfd_apb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] o_capacity
);
    import zrfd_pkg::*;

    logic [31:0] r_capacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RST;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_capacity <= pwdata;
        end
    end

    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? 32'd0 : r_capacity;
    assign o_capacity = r_capacity;

endmodule

// ===== design/zrfd_parser.sv =====
// Frame parser: holds the decode state and turns one accepted byte into
// up to one data or run word plus one status word. Depends on zrfd_pkg.
module zrfd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  zrfd_pkg::t_in_word i_word,
    input  logic [31:0]       i_capacity,
    output zrfd_pkg::t_push   o_push
);
    import zrfd_pkg::*;

    localparam logic [3:0] PH_MAGIC  = 4'd0;
    localparam logic [3:0] PH_DESC   = 4'd1;
    localparam logic [3:0] PH_WINDOW = 4'd2;
    localparam logic [3:0] PH_DICT   = 4'd3;
    localparam logic [3:0] PH_FCS    = 4'd4;
    localparam logic [3:0] PH_BHDR   = 4'd5;
    localparam logic [3:0] PH_RAW    = 4'd6;
    localparam logic [3:0] PH_RLE    = 4'd7;
    localparam logic [3:0] PH_DONE   = 4'd8;
    localparam logic [3:0] PH_ERR    = 4'd9;

    logic [3:0]  r_phase,     n_phase;
    logic [3:0]  r_fcnt,      n_fcnt;
    logic [31:0] r_magic,     n_magic;
    logic [1:0]  r_size_code, n_size_code;
    logic [2:0]  r_dict_rem,  n_dict_rem;
    logic [63:0] r_decl,      n_decl;
    logic [23:0] r_hdr,       n_hdr;
    logic [20:0] r_blk_rem,   n_blk_rem;
    logic        r_blk_last,  n_blk_last;
    logic [31:0] r_prod,      n_prod;
    logic [3:0]  r_fcs_len,   n_fcs_len;

    logic [7:0]  b;
    logic [3:0]  fcnt_inc;
    logic [23:0] hdr_new;
    logic [20:0] bsize;
    logic [1:0]  btype;
    logic        over;
    logic        go_dict, go_fcs, go_bhdr, done_req;
    logic        data_v, stat_v;
    logic [1:0]  data_kind;
    logic [20:0] data_len;
    logic [3:0]  stat_code;
    logic [31:0] stat_total;
    logic [3:0]  last_code;

    always_comb begin
        b        = i_word.in_byte;
        fcnt_inc = r_fcnt + 4'd1;
        hdr_new  = r_hdr | (24'(b) << {r_fcnt[1:0], 3'b000});
        bsize    = hdr_new[23:3];
        btype    = hdr_new[2:1];
        over     = ({1'b0, r_prod} + 33'(bsize)) > {1'b0, i_capacity};

        n_phase     = r_phase;
        n_fcnt      = r_fcnt;
        n_magic     = r_magic;
        n_size_code = r_size_code;
        n_dict_rem  = r_dict_rem;
        n_decl      = r_decl;
        n_hdr       = r_hdr;
        n_blk_rem   = r_blk_rem;
        n_blk_last  = r_blk_last;
        n_prod      = r_prod;
        n_fcs_len   = r_fcs_len;

        go_dict    = 1'b0;
        go_fcs     = 1'b0;
        go_bhdr    = 1'b0;
        done_req   = 1'b0;
        data_v     = 1'b0;
        data_kind  = KIND_DATA;
        data_len   = 21'd1;
        stat_v     = 1'b0;
        stat_code  = ST_OK;
        stat_total = 32'd0;
        last_code  = ST_OK;

        unique case (r_phase)
            PH_MAGIC: begin
                n_magic = {b, r_magic[31:8]};
                n_fcnt  = fcnt_inc;
                if (fcnt_inc >= 4'd4) begin
                    if (n_magic != FRAME_MAGIC) begin
                        stat_v    = 1'b1;
                        stat_code = ST_BAD_MAGIC;
                        n_phase   = PH_ERR;
                    end else begin
                        n_phase = PH_DESC;
                    end
                end
            end
            PH_DESC: begin
                n_size_code = b[7:6];
                n_dict_rem  = (b[1:0] == 2'd3) ? 3'd4 : {1'b0, b[1:0]};
                unique case (b[7:6])
                    2'd0:    n_fcs_len = {3'b000, b[5]};
                    2'd1:    n_fcs_len = 4'd2;
                    2'd2:    n_fcs_len = 4'd4;
                    default: n_fcs_len = 4'd8;
                endcase
                n_decl = 64'd0;
                if (b[5]) begin
                    go_dict = 1'b1;
                end else begin
                    n_phase = PH_WINDOW;
                end
            end
            PH_WINDOW: begin
                go_dict = 1'b1;
            end
            PH_DICT: begin
                n_dict_rem = r_dict_rem - 3'd1;
                if (n_dict_rem == 3'd0) begin
                    go_fcs = 1'b1;
                end
            end
            PH_FCS: begin
                n_decl = r_decl | (64'(b) << {r_fcnt[2:0], 3'b000});
                n_fcnt = fcnt_inc;
                if (fcnt_inc >= r_fcs_len) begin
                    if (r_size_code == 2'd1) begin
                        n_decl = {47'd0, 17'(n_decl[15:0]) + 17'd256};
                    end
                    go_bhdr = 1'b1;
                end
            end
            PH_BHDR: begin
                n_hdr  = hdr_new;
                n_fcnt = fcnt_inc;
                if (fcnt_inc >= 4'd3) begin
                    n_blk_last = hdr_new[0];
                    if (btype == 2'd0) begin
                        if (over) begin
                            stat_v    = 1'b1;
                            stat_code = ST_RAW_ERR;
                            n_phase   = PH_ERR;
                        end else if (bsize == 21'd0) begin
                            done_req = 1'b1;
                        end else begin
                            n_blk_rem = bsize;
                            n_phase   = PH_RAW;
                        end
                    end else if (btype == 2'd1) begin
                        if (over) begin
                            stat_v    = 1'b1;
                            stat_code = ST_RLE_ERR;
                            n_phase   = PH_ERR;
                        end else begin
                            n_blk_rem = bsize;
                            n_phase   = PH_RLE;
                        end
                    end else begin
                        stat_v    = 1'b1;
                        stat_code = ST_BAD_TYPE;
                        n_phase   = PH_ERR;
                    end
                end
            end
            PH_RAW: begin
                data_v    = 1'b1;
                data_kind = KIND_DATA;
                data_len  = 21'd1;
                n_prod    = r_prod + 32'd1;
                n_blk_rem = r_blk_rem - 21'd1;
                if (n_blk_rem == 21'd0) begin
                    done_req = 1'b1;
                end
            end
            PH_RLE: begin
                if (r_blk_rem != 21'd0) begin
                    data_v    = 1'b1;
                    data_kind = KIND_RUN;
                    data_len  = r_blk_rem;
                    n_prod    = r_prod + 32'(r_blk_rem);
                end
                done_req = 1'b1;
            end
            default: begin
            end
        endcase

        if (done_req) begin
            if (n_blk_last) begin
                if (r_decl != 64'd0 && r_decl != {32'd0, n_prod}) begin
                    stat_v    = 1'b1;
                    stat_code = ST_SIZE_MISM;
                    n_phase   = PH_ERR;
                end else begin
                    stat_v     = 1'b1;
                    stat_code  = ST_OK;
                    stat_total = n_prod;
                    n_phase    = PH_DONE;
                end
            end else begin
                go_bhdr = 1'b1;
            end
        end
        if (go_dict) begin
            if (n_dict_rem != 3'd0) begin
                n_phase = PH_DICT;
            end else begin
                go_fcs = 1'b1;
            end
        end
        if (go_fcs) begin
            if (n_fcs_len != 4'd0) begin
                n_fcnt  = 4'd0;
                n_phase = PH_FCS;
            end else begin
                go_bhdr = 1'b1;
            end
        end
        if (go_bhdr) begin
            n_fcnt  = 4'd0;
            n_hdr   = 24'd0;
            n_phase = PH_BHDR;
        end

        if (i_word.in_last) begin
            unique case (n_phase)
                PH_MAGIC, PH_DESC:  last_code = ST_BAD_MAGIC;
                PH_WINDOW, PH_DICT: last_code = ST_HDR_TRUNC;
                PH_FCS:             last_code = ST_SIZE_TRUNC;
                PH_BHDR:            last_code = ST_BHDR_TRUNC;
                PH_RAW:             last_code = ST_RAW_ERR;
                PH_RLE:             last_code = ST_RLE_ERR;
                default:            last_code = ST_OK;
            endcase
            if (last_code != ST_OK) begin
                stat_v     = 1'b1;
                stat_code  = last_code;
                stat_total = 32'd0;
            end
            n_phase     = PH_MAGIC;
            n_fcnt      = 4'd0;
            n_magic     = 32'd0;
            n_size_code = 2'd0;
            n_dict_rem  = 3'd0;
            n_decl      = 64'd0;
            n_hdr       = 24'd0;
            n_blk_rem   = 21'd0;
            n_blk_last  = 1'b0;
            n_prod      = 32'd0;
            n_fcs_len   = 4'd0;
        end

        o_push.data_v            = i_accept && data_v;
        o_push.stat_v            = i_accept && stat_v;
        o_push.data_w.out_kind   = data_kind;
        o_push.data_w.out_value  = b;
        o_push.data_w.run_length = data_len;
        o_push.data_w.status     = ST_OK;
        o_push.data_w.out_total  = 32'd0;
        o_push.data_w.out_last   = !stat_v;
        o_push.stat_w.out_kind   = KIND_STATUS;
        o_push.stat_w.out_value  = 8'd0;
        o_push.stat_w.run_length = 21'd1;
        o_push.stat_w.status     = stat_code;
        o_push.stat_w.out_total  = stat_total;
        o_push.stat_w.out_last   = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_fcnt      <= 4'd0;
            r_magic     <= 32'd0;
            r_size_code <= 2'd0;
            r_dict_rem  <= 3'd0;
            r_decl      <= 64'd0;
            r_hdr       <= 24'd0;
            r_blk_rem   <= 21'd0;
            r_blk_last  <= 1'b0;
            r_prod      <= 32'd0;
            r_fcs_len   <= 4'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_fcnt      <= n_fcnt;
            r_magic     <= n_magic;
            r_size_code <= n_size_code;
            r_dict_rem  <= n_dict_rem;
            r_decl      <= n_decl;
            r_hdr       <= n_hdr;
            r_blk_rem   <= n_blk_rem;
            r_blk_last  <= n_blk_last;
            r_prod      <= n_prod;
            r_fcs_len   <= n_fcs_len;
        end
    end

endmodule

// ===== design/zrfd_ofifo.sv =====
// Result queue: takes up to two words a cycle from the parser and hands
// out one word a cycle while the output is not stalled. Depends on zrfd_pkg.
module zrfd_ofifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zrfd_pkg::t_push     i_push,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output zrfd_pkg::t_out_word o_out_word,
    output logic                o_almost_full
);
    import zrfd_pkg::*;

    t_out_word             r_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]   r_wr, r_rd;
    logic [OFIFO_CW-1:0]   r_cnt;
    logic                  pop;
    logic [OFIFO_AW-1:0]   stat_addr;
    logic [OFIFO_CW-1:0]   n_push;

    assign pop           = (r_cnt != '0) && !i_out_stall;
    assign stat_addr     = r_wr + OFIFO_AW'(i_push.data_v);
    assign n_push        = OFIFO_CW'(i_push.data_v) + OFIFO_CW'(i_push.stat_v);
    assign o_out_valid   = (r_cnt != '0);
    assign o_out_word    = r_mem[r_rd];
    assign o_almost_full = r_cnt > OFIFO_CW'(OFIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push.data_v) begin
            r_mem[r_wr] <= i_push.data_w;
        end
        if (i_push.stat_v) begin
            r_mem[stat_addr] <= i_push.stat_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + OFIFO_AW'(n_push);
            r_rd  <= r_rd + OFIFO_AW'(pop);
            r_cnt <= r_cnt + n_push - OFIFO_CW'(pop);
        end
    end

endmodule

// ===== design/zstd_raw_rle_frame_decoder.sv =====
// Top level of the raw/RLE frame decoder.
// Instantiates zrfd_apb, zrfd_parser and zrfd_ofifo; depends on zrfd_pkg.
//
// The input channel takes one compressed byte per word, with in_last set on
// the final byte of a buffer. The output channel gives data bytes, runs and
// end status words; out_last marks the last word caused by one input byte.
// Each input byte is parsed in the cycle it is accepted, and its words are
// written into a four-entry result queue and shown on the output in order.
// One byte is accepted every cycle while the queue has room for two words;
// a byte that causes two words (a final raw byte and its status) takes two
// queue entries, so the sustained rate is one byte per cycle only at one
// word per byte.
// When the receiver stalls, the head word holds and the queue fills; the
// input channel stalls as soon as fewer than two entries are free.
// Reset clears the parse state, empties the queue and sets the capacity
// register to 1048576. The capacity register sits at byte address 0 and
// should only be written while no frame is in flight.
module zstd_raw_rle_frame_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zrfd_pkg::t_in_word  i_in_word,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output zrfd_pkg::t_out_word o_out_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import zrfd_pkg::*;

    logic        accept;
    logic [31:0] capacity;
    t_push       push;

    assign accept = i_in_valid && !o_in_stall;

    zrfd_apb u_apb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    zrfd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_in_word),
        .i_capacity (capacity),
        .o_push     (push)
    );

    zrfd_ofifo u_ofifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word),
        .o_almost_full (o_in_stall)
    );

endmodule

// ===== design/zrfd_chk.sv =====
// Port-level checker for the raw/RLE frame decoder, bound to the top level.
// Depends on zrfd_pkg.
module zrfd_chk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zrfd_pkg::t_out_word o_out_word,
    input  logic                o_out_valid,
    input  logic                i_out_stall
);
    import zrfd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.out_kind == KIND_STATUS |-> o_out_word.out_last)
        else $error("status word not marked last");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.out_kind != KIND_STATUS
            |-> o_out_word.status == ST_OK && o_out_word.out_total == 32'd0
                && o_out_word.run_length != 21'd0)
        else $error("data or run word carries status fields");

endmodule

bind zstd_raw_rle_frame_decoder zrfd_chk u_chk (.*);
